// ===== sv/pmu_pkg.sv =====
package pmu_pkg;

  localparam int unsigned MAX_TERMS_DEF = 32;
  localparam int unsigned COEF_W        = 24;
  localparam int unsigned PROD_W        = 53;
  localparam int unsigned DEG_W         = 6;

  // one input beat
  typedef struct packed {
    logic                     req_type;
    logic signed [COEF_W-1:0] coef_value;
    logic                     last_coef;
  } pmu_in_t;

  // one result beat
  typedef struct packed {
    logic signed [PROD_W-1:0] product_coef;
    logic [DEG_W-1:0]         degree;
    logic                     last_term;
  } pmu_out_t;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic                     step;
    logic                     clr;
    logic signed [COEF_W-1:0] x;
    logic signed [COEF_W-1:0] coef;
  } pmu_cell_ctl_t;

endpackage

// ===== sv/pmu_cell.sv =====
module pmu_cell (
  input  logic                            clk,
  input  pmu_pkg::pmu_cell_ctl_t          ctl,
  input  logic                            a_wr,
  input  logic                            b_wr,
  input  logic                            a_act,
  input  logic signed [pmu_pkg::COEF_W-1:0] b_next,
  input  logic signed [pmu_pkg::PROD_W-1:0] s_next,
  output logic signed [pmu_pkg::COEF_W-1:0] b_q,
  output logic signed [pmu_pkg::PROD_W-1:0] s_q
);
  import pmu_pkg::*;

  logic signed [COEF_W-1:0]   a_r;
  logic signed [COEF_W-1:0]   b_r;
  logic signed [PROD_W-1:0]   s_r;
  logic signed [2*COEF_W-1:0] prod;
  logic signed [PROD_W-1:0]   s_nxt;

  // tap product, zero for taps above the first polynomial's length
  always_comb begin
    if (a_act) begin
      prod = a_r * ctl.x;
    end else begin
      prod = '0;
    end
    s_nxt = PROD_W'(prod) + s_next;
  end

  always_ff @(posedge clk) begin
    if (a_wr) begin
      a_r <= ctl.coef;
    end
    if (b_wr) begin
      b_r <= ctl.coef;
    end else if (ctl.step) begin
      b_r <= b_next;
    end
    if (ctl.clr) begin
      s_r <= '0;
    end else if (ctl.step) begin
      s_r <= s_nxt;
    end
  end

  assign b_q = b_r;
  assign s_q = s_r;

endmodule

// ===== sv/polynomial_multiplier_unit.sv =====
// Polynomial multiplier by linear convolution. Coefficients (signed Q12.12) come in
// lowest degree first: the first polynomial (req_type 0), then the second (req_type 1).
// A beat is taken when start is high and busy is low. The beat with the second polynomial's
// last coefficient starts, if first_len + second_len is at least 2, a burst of
// first_len + second_len - 1 Q29.24 products in rising degree, one per cycle, each
// shown on out_data for exactly one cycle with out_valid high; the receiver cannot stall,
// so it must take every result as it comes. busy is high for the whole burst, while the
// chain of cells advances one degree per cycle; the first result appears in the cycle
// after busy rises, and the final result shows in the first cycle with busy low, when a
// new beat may already be taken.
// Coefficients beyond MAX_TERMS are dropped (a last mark on them still counts).
module polynomial_multiplier_unit #(
  parameter int unsigned MAX_TERMS = pmu_pkg::MAX_TERMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pmu_pkg::pmu_in_t  in_data,
  output logic              busy,
  output logic              out_valid,
  output pmu_pkg::pmu_out_t out_data
);
  import pmu_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_TERMS + 1);
  localparam int unsigned SUM_W = LEN_W + 1;

  typedef enum logic {ST_LOAD, ST_BURST} state_t;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   first_len_r, first_len_nxt;
  logic [LEN_W-1:0]   second_len_r, second_len_nxt;
  logic               first_closed_r, first_closed_nxt;
  logic [LEN_W-1:0]   b_left_r, b_left_nxt;     // second-poly taps still to feed
  logic [DEG_W-1:0]   deg_r, deg_nxt;           // degree being stepped
  logic [DEG_W-1:0]   last_deg_r, last_deg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DEG_W-1:0]   out_deg_r, out_deg_nxt;
  logic               out_last_r, out_last_nxt;

  logic               accept;
  logic               wr_a_en;
  logic               wr_b_en;
  logic [LEN_W-1:0]   base1;
  logic [LEN_W-1:0]   len2_new;
  logic [SUM_W-1:0]   sum;
  pmu_cell_ctl_t      ctl;

  logic [MAX_TERMS-1:0]     a_wr;
  logic [MAX_TERMS-1:0]     b_wr;
  logic [MAX_TERMS-1:0]     a_act;
  logic signed [COEF_W-1:0] b_q    [MAX_TERMS];
  logic signed [COEF_W-1:0] b_next [MAX_TERMS];
  logic signed [PROD_W-1:0] s_q    [MAX_TERMS];
  logic signed [PROD_W-1:0] s_next [MAX_TERMS];

  assign busy   = (state_r == ST_BURST);
  assign accept = start && !busy;

  // a req_type 0 beat after the first polynomial was closed starts a fresh load
  assign base1    = first_closed_r ? '0 : first_len_r;
  assign wr_a_en  = accept && !in_data.req_type && (base1 < LEN_W'(MAX_TERMS));
  assign wr_b_en  = accept && in_data.req_type && (second_len_r < LEN_W'(MAX_TERMS));
  assign len2_new = second_len_r + LEN_W'(wr_b_en);
  assign sum      = SUM_W'(first_len_r) + SUM_W'(len2_new);

  always_comb begin
    state_nxt        = state_r;
    first_len_nxt    = first_len_r;
    second_len_nxt   = second_len_r;
    first_closed_nxt = first_closed_r;
    b_left_nxt       = b_left_r;
    deg_nxt          = deg_r;
    last_deg_nxt     = last_deg_r;
    out_valid_nxt    = 1'b0;
    out_deg_nxt      = out_deg_r;
    out_last_nxt     = out_last_r;
    ctl.step         = 1'b0;
    ctl.clr          = 1'b0;
    ctl.coef         = in_data.coef_value;
    // feed the chain from its head, zeros once the second polynomial is used up
    ctl.x            = (b_left_r != '0) ? b_q[0] : '0;

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (!in_data.req_type) begin
            first_len_nxt    = base1 + LEN_W'(wr_a_en);
            second_len_nxt   = first_closed_r ? '0 : second_len_r;
            first_closed_nxt = in_data.last_coef;
          end else begin
            second_len_nxt = len2_new;
            if (in_data.last_coef) begin
              if (sum < SUM_W'(2)) begin
                // nothing to emit, just drop both loads
                first_len_nxt    = '0;
                second_len_nxt   = '0;
                first_closed_nxt = 1'b0;
              end else begin
                state_nxt    = ST_BURST;
                b_left_nxt   = len2_new;
                deg_nxt      = '0;
                last_deg_nxt = DEG_W'(sum - SUM_W'(2));
                ctl.clr      = 1'b1;
              end
            end
          end
        end
      end
      ST_BURST: begin
        ctl.step      = 1'b1;
        b_left_nxt    = (b_left_r != '0) ? b_left_r - LEN_W'(1) : b_left_r;
        deg_nxt       = deg_r + DEG_W'(1);
        out_valid_nxt = 1'b1;
        out_deg_nxt   = deg_r;
        out_last_nxt  = (deg_r == last_deg_r);
        if (deg_r == last_deg_r) begin
          state_nxt        = ST_LOAD;
          first_len_nxt    = '0;
          second_len_nxt   = '0;
          first_closed_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_LOAD;
      first_len_r    <= '0;
      second_len_r   <= '0;
      first_closed_r <= 1'b0;
      b_left_r       <= '0;
      deg_r          <= '0;
      last_deg_r     <= '0;
      out_valid_r    <= 1'b0;
      out_deg_r      <= '0;
      out_last_r     <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      first_len_r    <= first_len_nxt;
      second_len_r   <= second_len_nxt;
      first_closed_r <= first_closed_nxt;
      b_left_r       <= b_left_nxt;
      deg_r          <= deg_nxt;
      last_deg_r     <= last_deg_nxt;
      out_valid_r    <= out_valid_nxt;
      out_deg_r      <= out_deg_nxt;
      out_last_r     <= out_last_nxt;
    end
  end

  // transposed convolution chain: cell i holds tap a_i and coefficient b_i,
  // partial sums flow toward cell 0, second polynomial shifts toward cell 0
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    assign a_wr[i]  = wr_a_en && (base1 == LEN_W'(i));
    assign b_wr[i]  = wr_b_en && (second_len_r == LEN_W'(i));
    assign a_act[i] = (LEN_W'(i) < first_len_r);

    if (i == MAX_TERMS - 1) begin : g_tail
      assign b_next[i] = '0;
      assign s_next[i] = '0;
    end else begin : g_body
      assign b_next[i] = b_q[i+1];
      assign s_next[i] = s_q[i+1];
    end

    pmu_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .a_wr   (a_wr[i]),
      .b_wr   (b_wr[i]),
      .a_act  (a_act[i]),
      .b_next (b_next[i]),
      .s_next (s_next[i]),
      .b_q    (b_q[i]),
      .s_q    (s_q[i])
    );
  end

  // head of the chain holds the finished sum for the degree just stepped
  assign out_valid = out_valid_r;
  always_comb begin
    out_data.product_coef = s_q[0];
    out_data.degree       = out_deg_r;
    out_data.last_term    = out_last_r;
  end

endmodule
